// ===== rtl/rcs_pkg.sv =====
`timescale 1ns / 1ps

package rcs_pkg;

    localparam int CURVE_POINTS = 12;
    localparam int CURVE_AW     = $clog2(CURVE_POINTS);
    localparam int CURVE_W      = 12;
    localparam int YAW_SIGN     = 1;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 11;

    localparam logic [10:0] RST_STICK_CENTRE = 11'd1500;
    localparam logic [6:0]  RST_RP_DEADBAND  = 7'd0;
    localparam logic [6:0]  RST_YAW_DEADBAND = 7'd0;
    localparam logic [10:0] RST_MIN_CHECK    = 11'd1100;
    localparam logic [10:0] RST_TPA_BP       = 11'd1500;
    localparam logic [6:0]  RST_TPA_MAX      = 7'd0;
    localparam logic [6:0]  RST_THR_MID      = 7'd50;
    localparam logic [6:0]  RST_THR_EXPO     = 7'd0;

    localparam logic [11:0] THR_MAX     = 12'd2000;
    localparam logic [10:0] MIN_CHK_MAX = 11'd1999;
    localparam logic [8:0]  AXIS_LIMIT  = 9'd500;
    localparam logic [6:0]  PCT_FULL    = 7'd100;
    localparam logic [6:0]  MID_MAX     = 7'd99;

    // pipelined long division: numerator, divisor and quotient widths
    localparam int DIV_NW = 21;
    localparam int DIV_DW = 11;
    localparam int DIV_QW = 10;

    localparam int IN_W   = 48;
    localparam int OUT_W  = 48;
    localparam int LAT    = 14;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        REG_STICK_CENTRE = 3'd0,
        REG_RP_DEADBAND  = 3'd1,
        REG_YAW_DEADBAND = 3'd2,
        REG_MIN_CHECK    = 3'd3,
        REG_TPA_BP       = 3'd4,
        REG_TPA_MAX      = 3'd5,
        REG_THR_MID      = 3'd6,
        REG_THR_EXPO     = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV1,
        ST_PROD,
        ST_DIV2,
        ST_STORE
    } t_bld_state;

    typedef struct packed {
        logic                we;
        logic [CURVE_AW-1:0] addr;
        logic [CURVE_W-1:0]  data;
    } t_curve_wr;

    typedef struct packed {
        logic signed [9:0] roll;
        logic signed [9:0] pitch;
        logic signed [9:0] yaw;
    } t_axis_cmds;

    typedef struct packed {
        logic       below;
        logic       above;
        logic [6:0] tmax;
    } t_tpa_flags;

endpackage

// ===== rtl/rcs_ram.sv =====
`timescale 1ns / 1ps

module rcs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 12,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/rcs_axis.sv =====
`timescale 1ns / 1ps

module rcs_axis (
    input  logic              i_clk,
    input  logic [11:0]       i_raw,
    input  logic [10:0]       i_centre,
    input  logic [6:0]        i_deadband,
    input  logic              i_invert,
    input  logic              i_zero,
    output logic signed [9:0] o_cmd
);

    logic              below;
    logic [11:0]       mag;
    logic [8:0]        clamped;
    logic [8:0]        m;
    logic              neg;
    logic signed [9:0] n_cmd;
    logic signed [9:0] r_cmd;

    always_comb begin
        below   = i_raw < {1'b0, i_centre};
        mag     = below ? ({1'b0, i_centre} - i_raw) : (i_raw - {1'b0, i_centre});
        clamped = (mag > {3'b0, rcs_pkg::AXIS_LIMIT}) ? rcs_pkg::AXIS_LIMIT : mag[8:0];
        m       = (clamped > {2'b0, i_deadband}) ? (clamped - {2'b0, i_deadband}) : 9'd0;
        neg     = below ^ i_invert;
        if (i_zero) begin
            n_cmd = '0;
        end else if (neg) begin
            n_cmd = -$signed({1'b0, m});
        end else begin
            n_cmd = $signed({1'b0, m});
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_cmd = r_cmd;

endmodule

// ===== rtl/rcs_div.sv =====
`timescale 1ns / 1ps

module rcs_div (
    input  logic                       i_clk,
    input  logic [rcs_pkg::DIV_NW-1:0] i_num,
    input  logic [rcs_pkg::DIV_DW-1:0] i_den,
    output logic [rcs_pkg::DIV_QW-1:0] o_quo
);

    localparam int NW = rcs_pkg::DIV_NW;
    localparam int DW = rcs_pkg::DIV_DW;
    localparam int QW = rcs_pkg::DIV_QW;

    logic [NW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [NW-1:0] den_sh;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign den_sh = NW'(den_in) << (QW - 1 - k);
        assign take   = rem_in >= den_sh;

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? (rem_in - den_sh) : rem_in;
            r_den[k] <= den_in;
            r_quo[k] <= quo_in | (QW'(take) << (QW - 1 - k));
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== rtl/rcs_curve.sv =====
`timescale 1ns / 1ps

module rcs_curve (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [6:0]         i_mid,
    input  logic [6:0]         i_expo,
    output logic               o_busy,
    output rcs_pkg::t_curve_wr o_wr
);

    rcs_pkg::t_bld_state r_state, n_state;
    logic [rcs_pkg::CURVE_AW-1:0] r_idx, n_idx;
    logic signed [8:0] r_d, n_d;
    logic [13:0] r_yy, n_yy;
    logic [13:0] r_d2, n_d2;
    logic [21:0] r_num, n_num;
    logic [13:0] r_rem, n_rem;
    logic [13:0] r_den, n_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;

    logic [6:0]        mid_c;
    logic [6:0]        expo_c;
    logic signed [8:0] d_c;
    logic [6:0]        absd_c;
    logic [6:0]        y_c;
    logic [6:0]        absd_r;
    logic [13:0]       f;
    logic [14:0]       rem_sh;
    logic              take;
    logic [39:0]       recip10;
    logic signed [19:0] v;

    assign mid_c  = (i_mid > rcs_pkg::MID_MAX) ? rcs_pkg::MID_MAX : i_mid;
    assign expo_c = (i_expo > rcs_pkg::PCT_FULL) ? rcs_pkg::PCT_FULL : i_expo;

    // next state
    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = rcs_pkg::ST_SETUP;
        end else begin
            unique case (r_state)
                rcs_pkg::ST_IDLE:  n_state = rcs_pkg::ST_IDLE;
                rcs_pkg::ST_SETUP: n_state = rcs_pkg::ST_MUL;
                rcs_pkg::ST_MUL:   n_state = rcs_pkg::ST_DIV1;
                rcs_pkg::ST_DIV1: begin
                    if (r_cnt == 5'd21) n_state = rcs_pkg::ST_PROD;
                end
                rcs_pkg::ST_PROD:  n_state = rcs_pkg::ST_DIV2;
                rcs_pkg::ST_DIV2:  n_state = rcs_pkg::ST_STORE;
                rcs_pkg::ST_STORE: begin
                    if (r_idx == rcs_pkg::CURVE_AW'(rcs_pkg::CURVE_POINTS - 1)) begin
                        n_state = rcs_pkg::ST_IDLE;
                    end else begin
                        n_state = rcs_pkg::ST_SETUP;
                    end
                end
                default: n_state = rcs_pkg::ST_IDLE;
            endcase
        end
    end

    // datapath: one point is d, y*y, expo*d*d/(y*y), then d*f/10
    always_comb begin
        d_c    = $signed(9'(r_idx) * 9'd10) - $signed({2'b0, mid_c});
        absd_c = (d_c < 0) ? 7'(-d_c) : 7'(d_c);
        if (d_c > 0) begin
            y_c = 7'd100 - mid_c;
        end else if (d_c < 0) begin
            y_c = mid_c;
        end else begin
            y_c = 7'd1;
        end
        absd_r = (r_d < 0) ? 7'(-r_d) : 7'(r_d);
        f      = 14'(rcs_pkg::PCT_FULL - expo_c) + r_num[13:0];
        rem_sh = {r_rem, r_num[21]};
        take   = rem_sh >= {1'b0, r_den};
        // divide by 10 through its reciprocal, exact for the product range
        recip10 = 40'(r_num[17:0]) * 40'd419431;

        n_idx = r_idx;
        n_d   = r_d;
        n_yy  = r_yy;
        n_d2  = r_d2;
        n_num = r_num;
        n_rem = r_rem;
        n_den = r_den;
        n_cnt = r_cnt;
        n_neg = r_neg;
        if (i_start) begin
            n_idx = '0;
        end else begin
            unique case (r_state)
                rcs_pkg::ST_SETUP: begin
                    n_d  = d_c;
                    n_yy = 14'(y_c) * 14'(y_c);
                    n_d2 = 14'(absd_c) * 14'(absd_c);
                end
                rcs_pkg::ST_MUL: begin
                    n_num = 22'(expo_c) * 22'(r_d2);
                    n_den = r_yy;
                    n_rem = '0;
                    n_cnt = '0;
                end
                rcs_pkg::ST_DIV1: begin
                    n_rem = take ? 14'(rem_sh - {1'b0, r_den}) : rem_sh[13:0];
                    n_num = {r_num[20:0], take};
                    n_cnt = r_cnt + 5'd1;
                end
                rcs_pkg::ST_PROD: begin
                    n_num = 22'(absd_r) * 22'(f);
                    n_neg = r_d < 0;
                end
                rcs_pkg::ST_DIV2: begin
                    n_num = 22'(recip10[39:22]);
                end
                rcs_pkg::ST_STORE: begin
                    if (r_idx != rcs_pkg::CURVE_AW'(rcs_pkg::CURVE_POINTS - 1)) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        v = 20'sd1000 + $signed(20'(mid_c * 10))
            + (r_neg ? -$signed({2'b0, r_num[17:0]}) : $signed({2'b0, r_num[17:0]}));
        o_busy    = r_state != rcs_pkg::ST_IDLE;
        o_wr.we   = r_state == rcs_pkg::ST_STORE;
        o_wr.addr = r_idx;
        if (v < 0) begin
            o_wr.data = '0;
        end else if (v > 20'sd4095) begin
            o_wr.data = 12'd4095;
        end else begin
            o_wr.data = v[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcs_pkg::ST_SETUP;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_d   <= n_d;
        r_yy  <= n_yy;
        r_d2  <= n_d2;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end

endmodule

// ===== rtl/rc_stick_command_shaper.sv =====
`timescale 1ns / 1ps

// channel   dir  width  content
// s_axis    in   48     radio sample: roll, pitch, yaw, throttle pulse widths
// m_axis    out  48     roll, pitch, yaw commands, throttle, pid scale percent
// cfg       in   3+11   register write, index and data, no read-back
//
// one sample per cycle while s_axis_tready is high; each sample passes through
// the 10-stage pipelined throttle and tpa dividers.
// after reset and after a write of throttle mid or expo the 12-point curve is
// rebuilt by an iterative unit, with s_axis_tready low.
// a 32-entry output queue absorbs m_axis stalls; input stalls once 32
// transactions are in the pipeline or the queue.

module rc_stick_command_shaper (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // roll_raw, pitch_raw, yaw_raw, throttle_raw (12b each)
    input  logic [rcs_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // roll_cmd, pitch_cmd, yaw_cmd (10b), throttle_cmd (11b), pid_scale_percent (7b)
    output logic [rcs_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        i_cfg_wr_en,
    input  logic [rcs_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [rcs_pkg::CFG_DW-1:0]  i_cfg_wdata
);

    localparam int LAT = rcs_pkg::LAT;
    localparam int FAW = rcs_pkg::FIFO_AW;

    logic [10:0] r_centre, r_min_check, r_tpa_bp;
    logic [6:0]  r_rp_db, r_yaw_db, r_tpa_max, r_mid, r_expo;

    logic accept, pop, busy, curve_start;
    rcs_pkg::t_curve_wr curve_wr;

    logic [11:0] roll_raw, pitch_raw, yaw_raw, thr_raw;
    assign roll_raw  = s_axis_tdata[11:0];
    assign pitch_raw = s_axis_tdata[23:12];
    assign yaw_raw   = s_axis_tdata[35:24];
    assign thr_raw   = s_axis_tdata[47:36];

    // configuration
    assign curve_start = i_cfg_wr_en && ((i_cfg_addr == rcs_pkg::REG_THR_MID)
                         || (i_cfg_addr == rcs_pkg::REG_THR_EXPO));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre    <= rcs_pkg::RST_STICK_CENTRE;
            r_rp_db     <= rcs_pkg::RST_RP_DEADBAND;
            r_yaw_db    <= rcs_pkg::RST_YAW_DEADBAND;
            r_min_check <= rcs_pkg::RST_MIN_CHECK;
            r_tpa_bp    <= rcs_pkg::RST_TPA_BP;
            r_tpa_max   <= rcs_pkg::RST_TPA_MAX;
            r_mid       <= rcs_pkg::RST_THR_MID;
            r_expo      <= rcs_pkg::RST_THR_EXPO;
        end else if (i_cfg_wr_en) begin
            unique case (rcs_pkg::t_cfg_reg'(i_cfg_addr))
                rcs_pkg::REG_STICK_CENTRE: r_centre    <= i_cfg_wdata;
                rcs_pkg::REG_RP_DEADBAND:  r_rp_db     <= i_cfg_wdata[6:0];
                rcs_pkg::REG_YAW_DEADBAND: r_yaw_db    <= i_cfg_wdata[6:0];
                rcs_pkg::REG_MIN_CHECK:    r_min_check <= i_cfg_wdata;
                rcs_pkg::REG_TPA_BP:       r_tpa_bp    <= i_cfg_wdata;
                rcs_pkg::REG_TPA_MAX:      r_tpa_max   <= i_cfg_wdata[6:0];
                rcs_pkg::REG_THR_MID:      r_mid       <= i_cfg_wdata[6:0];
                rcs_pkg::REG_THR_EXPO:     r_expo      <= i_cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    rcs_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (curve_start),
        .i_mid   (r_mid),
        .i_expo  (r_expo),
        .o_busy  (busy),
        .o_wr    (curve_wr)
    );

    // stage 1: axis lanes and divider operands
    rcs_pkg::t_axis_cmds axis_s1;

    rcs_axis u_roll (
        .i_clk (i_clk), .i_raw (roll_raw), .i_centre (r_centre),
        .i_deadband (r_rp_db), .i_invert (1'b0), .i_zero (1'b0), .o_cmd (axis_s1.roll)
    );
    rcs_axis u_pitch (
        .i_clk (i_clk), .i_raw (pitch_raw), .i_centre (r_centre),
        .i_deadband (r_rp_db), .i_invert (1'b0), .i_zero (1'b0), .o_cmd (axis_s1.pitch)
    );
    rcs_axis u_yaw (
        .i_clk (i_clk), .i_raw (yaw_raw), .i_centre (r_centre),
        .i_deadband (r_yaw_db), .i_invert (rcs_pkg::YAW_SIGN > 0),
        .i_zero (rcs_pkg::YAW_SIGN == 0), .o_cmd (axis_s1.yaw)
    );

    logic [10:0] mc, tc;
    logic [11:0] t_con;
    logic [6:0]  tmax;
    logic        tpa_below, tpa_above, tpa_mid;
    logic [rcs_pkg::DIV_NW-1:0] n_num_s, n_num_p, r_num_s, r_num_p;
    logic [rcs_pkg::DIV_DW-1:0] n_den_s, n_den_p, r_den_s, r_den_p;
    rcs_pkg::t_tpa_flags r_tpa_s1;

    always_comb begin
        mc = (r_min_check > rcs_pkg::MIN_CHK_MAX) ? rcs_pkg::MIN_CHK_MAX : r_min_check;
        if (thr_raw < {1'b0, mc}) begin
            t_con = {1'b0, mc};
        end else if (thr_raw > rcs_pkg::THR_MAX) begin
            t_con = rcs_pkg::THR_MAX;
        end else begin
            t_con = thr_raw;
        end
        tc      = 11'(t_con - {1'b0, mc});
        n_den_s = 11'(rcs_pkg::THR_MAX - {1'b0, mc});
        n_num_s = rcs_pkg::DIV_NW'(tc) * 21'd1000;

        tmax      = (r_tpa_max > rcs_pkg::PCT_FULL) ? rcs_pkg::PCT_FULL : r_tpa_max;
        tpa_below = thr_raw < {1'b0, r_tpa_bp};
        tpa_above = !tpa_below && (thr_raw >= rcs_pkg::THR_MAX);
        tpa_mid   = !tpa_below && !tpa_above;
        if (tpa_mid) begin
            n_num_p = rcs_pkg::DIV_NW'(tmax)
                      * rcs_pkg::DIV_NW'(11'(thr_raw - {1'b0, r_tpa_bp}));
            n_den_p = 11'(rcs_pkg::THR_MAX - {1'b0, r_tpa_bp});
        end else begin
            n_num_p = '0;
            n_den_p = 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num_s  <= n_num_s;
        r_den_s  <= n_den_s;
        r_num_p  <= n_num_p;
        r_den_p  <= n_den_p;
        r_tpa_s1 <= '{below: tpa_below, above: tpa_above, tmax: tmax};
    end

    // stages 2..11: dividers
    logic [rcs_pkg::DIV_QW-1:0] quo_s, quo_p;

    rcs_div u_div_thr (.i_clk (i_clk), .i_num (r_num_s), .i_den (r_den_s), .o_quo (quo_s));
    rcs_div u_div_tpa (.i_clk (i_clk), .i_num (r_num_p), .i_den (r_den_p), .o_quo (quo_p));

    logic                r_vld [0:LAT-1];
    rcs_pkg::t_axis_cmds r_axd [0:LAT-2];
    rcs_pkg::t_tpa_flags r_tpd [0:9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= accept;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
        r_axd[0] <= axis_s1;
        for (int k = 1; k < LAT - 1; k++) r_axd[k] <= r_axd[k-1];
        r_tpd[0] <= r_tpa_s1;
        for (int k = 1; k < 10; k++) r_tpd[k] <= r_tpd[k-1];
    end

    // stage 11: segment select, curve read, tpa result
    logic [19:0] l_prod;
    logic [rcs_pkg::CURVE_AW-1:0] seg, seg_nx;
    logic [6:0] frac, prop;
    logic [rcs_pkg::CURVE_W-1:0] c0, c1;
    logic [6:0] r_frac12, r_prop12;

    always_comb begin
        l_prod = 20'(quo_s) * 20'd656;
        if (l_prod[19:16] > 4'(rcs_pkg::CURVE_POINTS - 2)) begin
            seg = rcs_pkg::CURVE_AW'(rcs_pkg::CURVE_POINTS - 2);
        end else begin
            seg = rcs_pkg::CURVE_AW'(l_prod[19:16]);
        end
        seg_nx = seg + 1'b1;
        frac   = 7'(quo_s - 10'(seg) * 10'd100);
        if (r_tpd[9].below) begin
            prop = rcs_pkg::PCT_FULL;
        end else if (r_tpd[9].above) begin
            prop = rcs_pkg::PCT_FULL - r_tpd[9].tmax;
        end else begin
            prop = rcs_pkg::PCT_FULL - quo_p[6:0];
        end
    end

    rcs_ram #(.WIDTH (rcs_pkg::CURVE_W), .DEPTH (rcs_pkg::CURVE_POINTS)) u_curve_ram (
        .i_clk     (i_clk),
        .i_we      (curve_wr.we),
        .i_waddr   (curve_wr.addr),
        .i_wdata   (curve_wr.data),
        .i_raddr_a (seg),
        .i_raddr_b (seg_nx),
        .o_rdata_a (c0),
        .o_rdata_b (c1)
    );

    always_ff @(posedge i_clk) begin
        r_frac12 <= frac;
        r_prop12 <= prop;
    end

    // stage 12: slope times fraction
    logic signed [12:0] cdiff;
    logic [11:0] cmag;
    logic [18:0] r_pm13, r_pm14;
    logic        r_neg13, r_neg14;
    logic [11:0] r_c013, r_c014;
    logic [6:0]  r_prop13, r_prop14;
    logic [12:0] r_q014;
    logic [34:0] recip;

    assign cdiff = $signed({1'b0, c1}) - $signed({1'b0, c0});
    assign cmag  = (cdiff < 0) ? 12'(-cdiff) : 12'(cdiff);
    // stage 13: divide by 100 through its reciprocal, short by at most one
    assign recip = 35'(r_pm13) * 35'd41943;

    always_ff @(posedge i_clk) begin
        r_pm13   <= 19'(cmag) * 19'(r_frac12);
        r_neg13  <= cdiff < 0;
        r_c013   <= c0;
        r_prop13 <= r_prop12;
        r_q014   <= recip[34:22];
        r_pm14   <= r_pm13;
        r_neg14  <= r_neg13;
        r_c014   <= r_c013;
        r_prop14 <= r_prop13;
    end

    // stage 14: correction and final throttle
    logic [18:0] rem100;
    logic [12:0] q100;
    logic signed [13:0] thr_sum;
    logic [rcs_pkg::OUT_W-1:0] result;

    always_comb begin
        rem100  = r_pm14 - 19'(r_q014) * 19'd100;
        q100    = r_q014 + 13'(rem100 >= 19'd100);
        thr_sum = $signed({2'b0, r_c014})
                  + (r_neg14 ? -$signed({1'b0, q100}) : $signed({1'b0, q100}));
        result  = {r_prop14, thr_sum[10:0], r_axd[LAT-2].yaw,
                   r_axd[LAT-2].pitch, r_axd[LAT-2].roll};
    end

    // output queue with in-flight credit count
    logic [rcs_pkg::OUT_W-1:0] r_fifo [0:rcs_pkg::FIFO_DEPTH-1];
    logic [FAW-1:0] r_wptr, r_rptr;
    logic [FAW:0]   r_fill, r_inflight;
    logic           push;

    assign push          = r_vld[LAT-1];
    assign s_axis_tready = !busy && (r_inflight < (FAW+1)'(rcs_pkg::FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_fill != '0;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_fifo[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_fill     <= '0;
            r_inflight <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + 1'b1;
            if (pop) r_rptr <= r_rptr + 1'b1;
            r_fill     <= r_fill + (FAW+1)'(push) - (FAW+1)'(pop);
            r_inflight <= r_inflight + (FAW+1)'(accept) - (FAW+1)'(pop);
        end
        if (push) r_fifo[r_wptr] <= result;
    end

endmodule
